>>> design/ghp_pkg.sv
// Shared types, constants and helpers for the gzip member header parser.
// Used by ghp_parser and gzip_header_parser_top.
package ghp_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 16;
  localparam int unsigned HLEN_W = 16;

  localparam logic [7:0] MAGIC_ID1    = 8'h1F;
  localparam logic [7:0] MAGIC_ID2    = 8'h8B;
  localparam logic [7:0] CM_DEFLATE   = 8'h08;
  localparam logic [7:0] FLG_RESERVED = 8'hE0;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  localparam logic [15:0] FIXED_SKIP = 16'd6;
  localparam logic [15:0] HCRC_SKIP  = 16'd2;

  // flag_bits layout (FLG byte bits 1..4)
  localparam int unsigned FB_HCRC    = 0;
  localparam int unsigned FB_EXTRA   = 1;
  localparam int unsigned FB_NAME    = 2;
  localparam int unsigned FB_COMMENT = 3;

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN_LO = 4'd5,
    PH_XLEN_HI = 4'd6,
    PH_XDATA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_DONE    = 4'd15
  } ghp_phase_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [HLEN_W-1:0] length;
  } ghp_result_t;

  // Next header part after 'done' finishes, driven by the flags.
  function automatic ghp_phase_t next_part(input ghp_phase_t done, input logic [3:0] flags);
    ghp_phase_t nxt;
    if (done == PH_FIXED && flags[FB_EXTRA]) begin
      nxt = PH_XLEN_LO;
    end else if ((done == PH_FIXED || done == PH_XDATA) && flags[FB_NAME]) begin
      nxt = PH_NAME;
    end else if (done != PH_COMMENT && flags[FB_COMMENT]) begin
      nxt = PH_COMMENT;
    end else if (flags[FB_HCRC]) begin
      nxt = PH_HCRC;
    end else begin
      nxt = PH_DONE;
    end
    return nxt;
  endfunction

endpackage

>>> design/ghp_in_reg.sv
// Input register of the gzip header parser: captures one byte transfer.
// Depends on nothing but the clock and reset.
module ghp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       take,       // downstream consumes the held byte this cycle
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic load;

  // Room when empty or when the held byte leaves this cycle.
  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

endmodule

>>> design/ghp_parser.sv
// Header parse state and one-byte step logic of the gzip header parser.
// Depends on ghp_pkg (phase codes, constants, next_part, result struct).
module ghp_parser #(
  parameter int unsigned LENGTH_BITS = ghp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                last_in,
  output ghp_pkg::ghp_result_t result
);

  localparam int unsigned CW = (LENGTH_BITS > ghp_pkg::HLEN_W) ? LENGTH_BITS : ghp_pkg::HLEN_W;

  ghp_pkg::ghp_phase_t    phase, phase_next, phase_adv;
  logic [LENGTH_BITS-1:0] bytes_seen, bytes_seen_next;
  logic [3:0]             flag_bits, flag_bits_next;
  logic [15:0]            skip_remaining, skip_next, skip_dec;
  logic                   result_given, result_given_next;

  logic                   fail;
  logic                   done_hit;
  logic [CW-1:0]          count_ext;

  assign skip_dec  = skip_remaining - 16'd1;
  assign count_ext = CW'(bytes_seen) + CW'(1);

  always_comb begin
    phase_next        = phase;
    bytes_seen_next   = bytes_seen;
    flag_bits_next    = flag_bits;
    skip_next         = skip_remaining;
    result_given_next = result_given;
    phase_adv         = phase;
    fail              = 1'b0;
    done_hit          = 1'b0;
    result            = '0;

    if (result_given) begin
      if (last_in) begin
        result_given_next = 1'b0;
        phase_next        = ghp_pkg::PH_MAGIC1;
        bytes_seen_next   = '0;
        flag_bits_next    = '0;
        skip_next         = '0;
      end
    end else begin
      if (&bytes_seen) begin
        fail = 1'b1;               // count would pass the length limit
      end else begin
        bytes_seen_next = bytes_seen + LENGTH_BITS'(1);
        case (phase)
          ghp_pkg::PH_MAGIC1: begin
            if (byte_in != ghp_pkg::MAGIC_ID1) fail = 1'b1;
            else phase_adv = ghp_pkg::PH_MAGIC2;
          end
          ghp_pkg::PH_MAGIC2: begin
            if (byte_in != ghp_pkg::MAGIC_ID2) fail = 1'b1;
            else phase_adv = ghp_pkg::PH_METHOD;
          end
          ghp_pkg::PH_METHOD: begin
            if (byte_in != ghp_pkg::CM_DEFLATE) fail = 1'b1;
            else phase_adv = ghp_pkg::PH_FLAGS;
          end
          ghp_pkg::PH_FLAGS: begin
            if ((byte_in & ghp_pkg::FLG_RESERVED) != ghp_pkg::ZERO_BYTE) begin
              fail = 1'b1;
            end else begin
              flag_bits_next = byte_in[4:1];
              skip_next      = ghp_pkg::FIXED_SKIP;
              phase_adv      = ghp_pkg::PH_FIXED;
            end
          end
          ghp_pkg::PH_FIXED: begin
            skip_next = skip_dec;
            if (skip_dec == 16'd0) phase_adv = ghp_pkg::next_part(ghp_pkg::PH_FIXED, flag_bits);
          end
          ghp_pkg::PH_XLEN_LO: begin
            skip_next = {8'd0, byte_in};
            phase_adv = ghp_pkg::PH_XLEN_HI;
          end
          ghp_pkg::PH_XLEN_HI: begin
            skip_next = {byte_in, skip_remaining[7:0]};
            if ({byte_in, skip_remaining[7:0]} == 16'd0)
              phase_adv = ghp_pkg::next_part(ghp_pkg::PH_XDATA, flag_bits);
            else
              phase_adv = ghp_pkg::PH_XDATA;
          end
          ghp_pkg::PH_XDATA: begin
            skip_next = skip_dec;
            if (skip_dec == 16'd0) phase_adv = ghp_pkg::next_part(ghp_pkg::PH_XDATA, flag_bits);
          end
          ghp_pkg::PH_NAME: begin
            if (byte_in == ghp_pkg::ZERO_BYTE)
              phase_adv = ghp_pkg::next_part(ghp_pkg::PH_NAME, flag_bits);
          end
          ghp_pkg::PH_COMMENT: begin
            if (byte_in == ghp_pkg::ZERO_BYTE)
              phase_adv = ghp_pkg::next_part(ghp_pkg::PH_COMMENT, flag_bits);
          end
          ghp_pkg::PH_HCRC: begin
            skip_next = skip_dec;
            if (skip_dec == 16'd0) phase_adv = ghp_pkg::PH_DONE;
          end
          default: begin
            fail = 1'b1;
          end
        endcase
        // HCRC is only entered via next_part; load its 2-byte count then.
        if (phase_adv == ghp_pkg::PH_HCRC && phase != ghp_pkg::PH_HCRC)
          skip_next = ghp_pkg::HCRC_SKIP;
        phase_next = phase_adv;
      end

      done_hit = !fail && (phase_adv == ghp_pkg::PH_DONE);
      if (done_hit || fail || last_in) begin
        result.valid  = 1'b1;
        result.ok     = done_hit;
        result.length = done_hit ? count_ext[ghp_pkg::HLEN_W-1:0] : '0;
        if (last_in) begin
          phase_next      = ghp_pkg::PH_MAGIC1;
          bytes_seen_next = '0;
          flag_bits_next  = '0;
          skip_next       = '0;
        end else begin
          result_given_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ghp_pkg::PH_MAGIC1;
      bytes_seen     <= '0;
      flag_bits      <= '0;
      skip_remaining <= '0;
      result_given   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      bytes_seen     <= bytes_seen_next;
      flag_bits      <= flag_bits_next;
      skip_remaining <= skip_next;
      result_given   <= result_given_next;
    end
  end

endmodule

>>> design/gzip_header_parser_top.sv
// Top level of the gzip member header parser (RFC 1952).
// Instantiates ghp_in_reg and ghp_parser; uses ghp_pkg for the result struct.

// The parser takes one byte per cycle from the input channel unless in_stall
// is high, and gives at most one result per buffer: header_ok = 1 with
// header_length on the byte that completes the header, or header_ok = 0
// (length 0) on the first rule violation, on a header that runs past
// 2^LENGTH_BITS - 1 bytes, or when last_byte arrives before the header is
// done. Bytes after a result are dropped up to last_byte, which re-arms the
// parser. A byte sits in the input register, the parse step runs in short
// logic and its result lands in the output register, where out_valid shows
// it; the step waits while that register holds an untaken result.
// The input stalls only while a byte is held and the output register holds
// an untaken result with out_stall high.
module gzip_header_parser_top #(
  parameter int unsigned LENGTH_BITS = ghp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        header_ok,
  output logic [15:0] header_length
);

  logic                 held_valid;
  logic [7:0]           held_byte;
  logic                 held_last;
  logic                 out_free;
  logic                 step;
  ghp_pkg::ghp_result_t result;

  // Output register can load when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  assign step     = held_valid && out_free;

  ghp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  ghp_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (held_byte),
    .last_in (held_last),
    .result  (result)
  );

  // Result register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid && out_free) begin
      header_ok     <= result.ok;
      header_length <= result.length;
    end
  end

endmodule

>>> dv/tb_gzip_header_parser_top.sv
`timescale 1ns / 1ps
// Testbench for gzip_header_parser_top: feeds byte buffers and checks each verdict.
// Depends on ghp_pkg and the parser RTL; keeps its own header-walk model in step.
module tb_gzip_header_parser_top;
  import ghp_pkg::*;

  localparam int LEN_BITS = LENGTH_BITS_DEFAULT;
  localparam longint unsigned HDR_LEN_MAX = (64'd1 << LEN_BITS) - 1;

  // FLG byte bits as they sit on the wire (bit 0 is FTEXT, ignored by the parser)
  localparam logic [7:0] FLG_FTEXT    = 8'h01;
  localparam logic [7:0] FLG_FHCRC    = 8'h02;
  localparam logic [7:0] FLG_FEXTRA   = 8'h04;
  localparam logic [7:0] FLG_FNAME    = 8'h08;
  localparam logic [7:0] FLG_FCOMMENT = 8'h10;
  localparam logic [7:0] FLG_ALL      = 8'h1F;

  typedef struct packed {
    logic              ok;
    logic [HLEN_W-1:0] length;
  } header_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        header_ok;
  logic [15:0] header_length;

  gzip_header_parser_top #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .header_ok    (header_ok),
    .header_length(header_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle knobs, percent of cycles; changed per phase by the main sequence.
  int unsigned byte_gap_pct = 0;
  int unsigned result_stall_pct = 0;

  // Verdicts the model has predicted but the DUT has not yet delivered.
  header_verdict_t pending_verdicts[$];

  // Model state: walk position, header byte count, FLG bits 1..4, skip counter,
  // and whether this buffer already got its verdict.
  ghp_phase_t      walk_phase = PH_MAGIC1;
  longint unsigned hdr_count = 0;
  logic [3:0]      opt_flags = '0;
  logic [15:0]     skip_left = '0;
  logic            verdict_sent = 1'b0;

  int fail_count = 0;
  int buffers_sent = 0;
  int bytes_sent = 0;
  int parsed_bytes = 0;
  int headers_ok = 0;
  int headers_bad = 0;

  // Bytes of the buffer being built; the final one goes out with last_byte set.
  logic [7:0] frame[$];

  // Receiver side: random stall, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < result_stall_pct);
  end

  function automatic void rearm_parser();
    walk_phase   = PH_MAGIC1;
    hdr_count    = 0;
    opt_flags    = '0;
    skip_left    = '0;
    verdict_sent = 1'b0;
  endfunction

  // Which optional part follows once 'fin' is complete. EXTRA only follows the
  // fixed bytes, NAME follows fixed/extra, COMMENT anything but itself, then HCRC.
  function automatic ghp_phase_t part_after(input ghp_phase_t fin);
    if (fin == PH_FIXED && opt_flags[FB_EXTRA]) return PH_XLEN_LO;
    if ((fin == PH_FIXED || fin == PH_XDATA) && opt_flags[FB_NAME]) return PH_NAME;
    if (fin != PH_COMMENT && opt_flags[FB_COMMENT]) return PH_COMMENT;
    if (opt_flags[FB_HCRC]) begin
      skip_left = HCRC_SKIP;
      return PH_HCRC;
    end
    return PH_DONE;
  endfunction

  // Advance the model by one accepted byte and queue the verdict it causes.
  task automatic track_header_byte(input logic [7:0] b, input logic lst);
    longint unsigned count;
    logic            bad;
    header_verdict_t v;
    if (verdict_sent) begin
      // post-verdict bytes are dropped; the last one re-arms
      if (lst) rearm_parser();
      return;
    end
    parsed_bytes++;
    bad = 1'b0;
    count = hdr_count + 1;
    if (count > HDR_LEN_MAX) begin
      bad = 1'b1;
    end else begin
      hdr_count = count;
      case (walk_phase)
        PH_MAGIC1: begin
          if (b != MAGIC_ID1) bad = 1'b1;
          else walk_phase = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (b != MAGIC_ID2) bad = 1'b1;
          else walk_phase = PH_METHOD;
        end
        PH_METHOD: begin
          if (b != CM_DEFLATE) bad = 1'b1;
          else walk_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          if ((b & FLG_RESERVED) != 8'h00) begin
            bad = 1'b1;
          end else begin
            opt_flags  = b[4:1];
            skip_left  = FIXED_SKIP;
            walk_phase = PH_FIXED;
          end
        end
        PH_FIXED: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) walk_phase = part_after(PH_FIXED);
        end
        PH_XLEN_LO: begin
          skip_left  = {8'h00, b};
          walk_phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_left = {b, skip_left[7:0]};
          if (skip_left == 16'd0) walk_phase = part_after(PH_XDATA);
          else walk_phase = PH_XDATA;
        end
        PH_XDATA: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) walk_phase = part_after(PH_XDATA);
        end
        PH_NAME: begin
          if (b == ZERO_BYTE) walk_phase = part_after(PH_NAME);
        end
        PH_COMMENT: begin
          if (b == ZERO_BYTE) walk_phase = part_after(PH_COMMENT);
        end
        PH_HCRC: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) walk_phase = PH_DONE;
        end
        default: bad = 1'b1;
      endcase
    end
    if (!bad && walk_phase == PH_DONE) begin
      v.ok = 1'b1;
      v.length = count[HLEN_W-1:0];
    end else if (bad || lst) begin
      v.ok = 1'b0;
      v.length = '0;
    end else begin
      return;
    end
    pending_verdicts.push_back(v);
    if (lst) rearm_parser();
    else verdict_sent = 1'b1;
  endtask

  // One byte transfer: optional random gap, then hold until accepted.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < byte_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    track_header_byte(b, lst);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    buffers_sent++;
  endtask

  // Sender goes quiet until every predicted verdict has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Fill frame with a well-formed header; random content, zero-terminated strings.
  task automatic build_header(input logic [7:0] flg, input int xlen,
                              input int name_len, input int cmt_len);
    frame = {};
    frame.push_back(MAGIC_ID1);
    frame.push_back(MAGIC_ID2);
    frame.push_back(CM_DEFLATE);
    frame.push_back(flg);
    repeat (FIXED_SKIP) frame.push_back(8'($urandom));
    if (flg & FLG_FEXTRA) begin
      frame.push_back(xlen[7:0]);
      frame.push_back(xlen[15:8]);
      repeat (xlen) frame.push_back(8'($urandom));
    end
    if (flg & FLG_FNAME) begin
      repeat (name_len) frame.push_back(8'($urandom_range(1, 255)));
      frame.push_back(ZERO_BYTE);
    end
    if (flg & FLG_FCOMMENT) begin
      repeat (cmt_len) frame.push_back(8'($urandom_range(1, 255)));
      frame.push_back(ZERO_BYTE);
    end
    if (flg & FLG_FHCRC) repeat (HCRC_SKIP) frame.push_back(8'($urandom));
  endtask

  task automatic add_tail(input int n);
    repeat (n) frame.push_back(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Bare 10-byte header: verdict on the last byte, then with trailing data.
  task automatic test_plain_header();
    build_header(8'h00, 0, 0, 0);
    send_frame();
    build_header(FLG_FTEXT, 0, 0, 0);   // FTEXT must not matter
    add_tail(3);
    send_frame();
  endtask

  // Each optional part alone, all of them together, and a zero-length extra field.
  task automatic test_optional_parts();
    build_header(FLG_FEXTRA, 2, 0, 0);
    add_tail(1);
    send_frame();
    build_header(FLG_FNAME, 0, 3, 0);
    add_tail(2);
    send_frame();
    build_header(FLG_FCOMMENT, 0, 0, 0);  // empty comment: just the terminator
    send_frame();
    build_header(FLG_FHCRC, 0, 0, 0);
    add_tail(1);
    send_frame();
    build_header(FLG_ALL, 3, 2, 4);
    add_tail(2);
    send_frame();
    build_header(FLG_FEXTRA | FLG_FNAME, 0, 1, 0);
    send_frame();
  endtask

  // One broken rule per buffer; the rest of the buffer must be dropped silently.
  task automatic test_rule_violations();
    build_header(8'h00, 0, 0, 0);
    frame[0] = 8'h00;
    send_frame();
    build_header(8'h00, 0, 0, 0);
    frame[1] = 8'h8A;
    add_tail(2);
    send_frame();
    build_header(8'h00, 0, 0, 0);
    frame[2] = 8'h09;
    send_frame();
    for (int k = 5; k < 8; k++) begin
      build_header(8'h00, 0, 0, 0);
      frame[3] = 8'h01 << k;    // one reserved FLG bit at a time
      send_frame();
    end
    frame = {8'hFF};            // wrong magic on the buffer's only byte
    send_frame();
  endtask

  // Buffer ends before the header does: fail on the last byte.
  task automatic test_truncated_buffers();
    frame = {MAGIC_ID1};
    send_frame();
    build_header(8'h00, 0, 0, 0);
    frame = frame[0:3];
    send_frame();
    build_header(FLG_FEXTRA, 5, 0, 0);
    frame = frame[0:13];        // inside the extra data
    send_frame();
    build_header(FLG_FNAME, 0, 4, 0);
    frame.pop_back();           // name never terminated
    send_frame();
    build_header(FLG_FHCRC, 0, 0, 0);
    frame.pop_back();           // one CRC byte short
    send_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Random buffers: mostly well-formed headers, mixed with broken, cut and noise ones.
  // ---------------------------------------------------------------------------
  task automatic test_random_buffers(input int n_bytes);
    int         stop_at;
    int         kind;
    int         cut;
    logic [7:0] flg;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      flg = 8'($urandom_range(0, 31));
      if (kind < 90) begin
        build_header(flg,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 6),
                     $urandom_range(0, 5), $urandom_range(0, 5));
      end
      if (kind < 65) begin
        add_tail($urandom_range(0, 3));
      end else if (kind < 80) begin
        cut = $urandom_range(0, 3);
        if (cut < 3) frame[cut] = frame[cut] ^ 8'($urandom_range(1, 255));
        else frame[3] = frame[3] | (8'h20 << $urandom_range(0, 2));
        add_tail($urandom_range(0, 3));
      end else if (kind < 90) begin
        cut = $urandom_range(1, frame.size());
        frame = frame[0:cut-1];
      end else begin
        frame = {};
        if ($urandom_range(0, 1)) frame.push_back(MAGIC_ID1);
        add_tail($urandom_range(1, 6));
      end
      send_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    header_verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: header_ok=%0b header_length=%0d",
               header_ok, header_length);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (header_ok !== want.ok) begin
          $error("header_ok: expected %0b, got %0b", want.ok, header_ok);
          fail_count++;
        end
        if (header_length !== want.length) begin
          $error("header_length: expected %0d, got %0d", want.length, header_length);
          fail_count++;
        end
        if (want.ok) headers_ok++;
        else headers_bad++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_plain_header();
    test_optional_parts();
    test_rule_violations();
    test_truncated_buffers();
    hold_until_drained();

    test_random_buffers(280);
    hold_until_drained();
    byte_gap_pct = 55;
    test_random_buffers(280);
    hold_until_drained();
    byte_gap_pct = 0;
    result_stall_pct = 55;
    test_random_buffers(280);
    hold_until_drained();
    byte_gap_pct = 35;
    result_stall_pct = 35;
    test_random_buffers(280);
    hold_until_drained();

    // pipeline is two deep; let any stray result show up
    repeat (8) @(posedge clk);

    $display("summary: %0d buffers, %0d bytes sent, %0d header bytes parsed, %0d accepted, %0d rejected",
             buffers_sent, bytes_sent, parsed_bytes, headers_ok, headers_bad);
    $display("summary: idle phases none / sender 55%% / receiver 55%% / both 35%%");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a fifth of this.
  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
